// ===== hdl/sc2a_pkg.sv =====
// Shared types, codes and translation tables for the scan code translator.
package sc2a_pkg;

  // Operation codes of an input word.
  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_RD_CHAR = 3'd1;
  localparam logic [2:0] OP_RD_RAW  = 3'd2;
  localparam logic [2:0] OP_LAST    = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;

  // Set 1 scan codes that drive the key flags.
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
  localparam logic [7:0] SC_ALT_MAKE     = 8'h38;

  // Highest code that may be printable, and first code that caps lock affects.
  localparam logic [7:0] PRINT_LIMIT = 8'h52;
  localparam logic [7:0] CAPS_FIRST  = 8'h10;

  // Result source selected for the word on the output.
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_CHAR = 2'd1,
    SRC_RAW  = 2'd2
  } src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;    // accept the word on the inputs and carry it out
    logic strobe;  // present the result of the word just carried out
  } cmd_t;

  // Character for a scan code with no shift; zero means not printable.
  function automatic logic [7:0] plain_char(input logic [7:0] code);
    logic [7:0] ch;
    case (code)
      8'h01: ch = 8'h1B;  8'h02: ch = 8'h31;  8'h03: ch = 8'h32;  8'h04: ch = 8'h33;
      8'h05: ch = 8'h34;  8'h06: ch = 8'h35;  8'h07: ch = 8'h36;  8'h08: ch = 8'h37;
      8'h09: ch = 8'h38;  8'h0A: ch = 8'h39;  8'h0B: ch = 8'h30;  8'h0C: ch = 8'h2D;
      8'h0D: ch = 8'h3D;  8'h0E: ch = 8'h08;  8'h0F: ch = 8'h09;  8'h10: ch = 8'h71;
      8'h11: ch = 8'h77;  8'h12: ch = 8'h65;  8'h13: ch = 8'h72;  8'h14: ch = 8'h74;
      8'h15: ch = 8'h79;  8'h16: ch = 8'h75;  8'h17: ch = 8'h69;  8'h18: ch = 8'h6F;
      8'h19: ch = 8'h70;  8'h1A: ch = 8'h5B;  8'h1B: ch = 8'h5D;  8'h1C: ch = 8'h0A;
      8'h1E: ch = 8'h61;  8'h1F: ch = 8'h73;  8'h20: ch = 8'h64;  8'h21: ch = 8'h66;
      8'h22: ch = 8'h67;  8'h23: ch = 8'h68;  8'h24: ch = 8'h6A;  8'h25: ch = 8'h6B;
      8'h26: ch = 8'h6C;  8'h27: ch = 8'h3B;  8'h28: ch = 8'h27;  8'h29: ch = 8'h60;
      8'h2B: ch = 8'h5C;  8'h2C: ch = 8'h7A;  8'h2D: ch = 8'h78;  8'h2E: ch = 8'h63;
      8'h2F: ch = 8'h76;  8'h30: ch = 8'h62;  8'h31: ch = 8'h6E;  8'h32: ch = 8'h6D;
      8'h33: ch = 8'h2C;  8'h34: ch = 8'h2E;  8'h35: ch = 8'h2F;  8'h37: ch = 8'h2A;
      8'h39: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Character for a scan code with shift applied.
  function automatic logic [7:0] upper_char(input logic [7:0] code);
    logic [7:0] ch;
    case (code)
      8'h01: ch = 8'h1B;  8'h02: ch = 8'h21;  8'h03: ch = 8'h40;  8'h04: ch = 8'h23;
      8'h05: ch = 8'h24;  8'h06: ch = 8'h25;  8'h07: ch = 8'h5E;  8'h08: ch = 8'h26;
      8'h09: ch = 8'h2A;  8'h0A: ch = 8'h28;  8'h0B: ch = 8'h29;  8'h0C: ch = 8'h5F;
      8'h0D: ch = 8'h2B;  8'h0E: ch = 8'h08;  8'h0F: ch = 8'h09;  8'h10: ch = 8'h51;
      8'h11: ch = 8'h57;  8'h12: ch = 8'h45;  8'h13: ch = 8'h52;  8'h14: ch = 8'h54;
      8'h15: ch = 8'h59;  8'h16: ch = 8'h55;  8'h17: ch = 8'h49;  8'h18: ch = 8'h4F;
      8'h19: ch = 8'h50;  8'h1A: ch = 8'h7B;  8'h1B: ch = 8'h7D;  8'h1C: ch = 8'h0A;
      8'h1E: ch = 8'h41;  8'h1F: ch = 8'h53;  8'h20: ch = 8'h44;  8'h21: ch = 8'h46;
      8'h22: ch = 8'h47;  8'h23: ch = 8'h48;  8'h24: ch = 8'h4A;  8'h25: ch = 8'h4B;
      8'h26: ch = 8'h4C;  8'h27: ch = 8'h3A;  8'h28: ch = 8'h22;  8'h29: ch = 8'h7C;
      8'h2B: ch = 8'h5C;  8'h2C: ch = 8'h5A;  8'h2D: ch = 8'h58;  8'h2E: ch = 8'h43;
      8'h2F: ch = 8'h56;  8'h30: ch = 8'h42;  8'h31: ch = 8'h4E;  8'h32: ch = 8'h4D;
      8'h33: ch = 8'h3C;  8'h34: ch = 8'h3E;  8'h35: ch = 8'h3F;  8'h37: ch = 8'h2A;
      8'h39: ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/sc2a_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module sc2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sc2a_ctrl.sv =====
// Controller state machine: accepts one word and schedules its result cycle.
module sc2a_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output sc2a_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DONE = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.exec   = 1'b0;
    cmd.strobe = 1'b0;
    busy       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.exec  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Registered read data is ready now; show the result for this cycle.
        busy       = 1'b1;
        cmd.strobe = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/sc2a_dpath.sv =====
// Datapath: key flags, translation, ring pointers and both ring memories.
module sc2a_dpath #(
  parameter int RING_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sc2a_pkg::cmd_t  cmd,
  input  logic [2:0]      in_operation,
  input  logic [7:0]      in_scan_code,
  output logic [7:0]      out_read_value,
  output logic            out_value_valid,
  output logic            out_alt_seen,
  output logic            out_ctrl_held
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic shift_r, shift_nxt, caps_r, caps_nxt, ctrl_r, ctrl_nxt, alt_r, alt_nxt;
  logic [PTR_W-1:0] raw_wr_r, raw_wr_nxt, raw_rd_r, raw_rd_nxt;
  logic [PTR_W-1:0] chr_wr_r, chr_wr_nxt, chr_rd_r, chr_rd_nxt;
  logic raw_pend_r, raw_pend_nxt, chr_pend_r, chr_pend_nxt;
  logic [RING_DEPTH-1:0] chr_vld_r, chr_vld_nxt;
  logic chr_rvld_r, hit_r, hit_nxt;
  sc2a_pkg::src_t src_r, src_nxt;

  logic [PTR_W-1:0] chr_raddr;
  logic [7:0] plain_ch, upper_ch, chr_wdata, chr_rdata, raw_rdata;
  logic chr_we, raw_we;

  assign plain_ch = sc2a_pkg::plain_char(in_scan_code);
  assign upper_ch = sc2a_pkg::upper_char(in_scan_code);

  always_comb begin
    shift_nxt    = shift_r;
    caps_nxt     = caps_r;
    ctrl_nxt     = ctrl_r;
    alt_nxt      = alt_r;
    raw_wr_nxt   = raw_wr_r;
    raw_rd_nxt   = raw_rd_r;
    chr_wr_nxt   = chr_wr_r;
    chr_rd_nxt   = chr_rd_r;
    raw_pend_nxt = raw_pend_r;
    chr_pend_nxt = chr_pend_r;
    chr_vld_nxt  = chr_vld_r;
    hit_nxt      = 1'b0;
    src_nxt      = sc2a_pkg::SRC_NONE;
    chr_we       = 1'b0;
    raw_we       = 1'b0;
    chr_wdata    = plain_ch;
    chr_raddr    = chr_rd_r;
    if (cmd.exec) begin
      case (in_operation)
        sc2a_pkg::OP_PUSH: begin
          if (in_scan_code inside {sc2a_pkg::SC_LSHIFT_MAKE, sc2a_pkg::SC_RSHIFT_MAKE}) begin
            shift_nxt = 1'b1;
          end
          if (in_scan_code inside {sc2a_pkg::SC_LSHIFT_BREAK,
                                   sc2a_pkg::SC_RSHIFT_BREAK}) begin
            shift_nxt = 1'b0;
          end
          if (in_scan_code == sc2a_pkg::SC_CAPS_MAKE) begin
            caps_nxt = ~caps_r;
          end
          if (in_scan_code == sc2a_pkg::SC_CTRL_MAKE) begin
            ctrl_nxt = 1'b1;
          end
          if (in_scan_code == sc2a_pkg::SC_CTRL_BREAK) begin
            ctrl_nxt = 1'b0;
          end
          if (in_scan_code == sc2a_pkg::SC_ALT_MAKE) begin
            alt_nxt = 1'b1;
          end
          // Translation sees the flags as updated by this very code.
          if (in_scan_code <= sc2a_pkg::PRINT_LIMIT && plain_ch != 8'h00) begin
            chr_we = 1'b1;
            if (shift_nxt || (caps_nxt && in_scan_code >= sc2a_pkg::CAPS_FIRST)) begin
              chr_wdata = upper_ch;
            end
            chr_vld_nxt[chr_wr_r] = 1'b1;
            chr_wr_nxt   = next_slot(chr_wr_r);
            chr_pend_nxt = 1'b1;
          end
          raw_we       = 1'b1;
          raw_wr_nxt   = next_slot(raw_wr_r);
          raw_pend_nxt = 1'b1;
        end
        sc2a_pkg::OP_RD_CHAR: begin
          if (chr_pend_r) begin
            hit_nxt      = 1'b1;
            src_nxt      = sc2a_pkg::SRC_CHAR;
            chr_rd_nxt   = next_slot(chr_rd_r);
            chr_pend_nxt = (next_slot(chr_rd_r) != chr_wr_r);
          end
        end
        sc2a_pkg::OP_RD_RAW: begin
          if (raw_pend_r) begin
            hit_nxt      = 1'b1;
            src_nxt      = sc2a_pkg::SRC_RAW;
            raw_rd_nxt   = next_slot(raw_rd_r);
            raw_pend_nxt = (next_slot(raw_rd_r) != raw_wr_r);
          end
        end
        sc2a_pkg::OP_LAST: begin
          chr_raddr = (chr_wr_r == '0) ? PTR_LAST : chr_wr_r - 1'b1;
          hit_nxt   = 1'b1;
          src_nxt   = sc2a_pkg::SRC_CHAR;
        end
        sc2a_pkg::OP_FLUSH: begin
          raw_wr_nxt   = '0;
          raw_rd_nxt   = '0;
          chr_wr_nxt   = '0;
          chr_rd_nxt   = '0;
          raw_pend_nxt = 1'b0;
          chr_pend_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= 1'b0;
      caps_r     <= 1'b0;
      ctrl_r     <= 1'b0;
      alt_r      <= 1'b0;
      raw_wr_r   <= '0;
      raw_rd_r   <= '0;
      chr_wr_r   <= '0;
      chr_rd_r   <= '0;
      raw_pend_r <= 1'b0;
      chr_pend_r <= 1'b0;
      chr_vld_r  <= '0;
      hit_r      <= 1'b0;
      src_r      <= sc2a_pkg::SRC_NONE;
      chr_rvld_r <= 1'b0;
    end else begin
      shift_r    <= shift_nxt;
      caps_r     <= caps_nxt;
      ctrl_r     <= ctrl_nxt;
      alt_r      <= alt_nxt;
      raw_wr_r   <= raw_wr_nxt;
      raw_rd_r   <= raw_rd_nxt;
      chr_wr_r   <= chr_wr_nxt;
      chr_rd_r   <= chr_rd_nxt;
      raw_pend_r <= raw_pend_nxt;
      chr_pend_r <= chr_pend_nxt;
      chr_vld_r  <= chr_vld_nxt;
      hit_r      <= hit_nxt;
      src_r      <= src_nxt;
      chr_rvld_r <= chr_vld_r[chr_raddr];
    end
  end

  sc2a_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_chr_ram (
    .clk   (clk),
    .we    (chr_we),
    .waddr (chr_wr_r),
    .wdata (chr_wdata),
    .raddr (chr_raddr),
    .rdata (chr_rdata)
  );

  sc2a_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_raw_ram (
    .clk   (clk),
    .we    (raw_we),
    .waddr (raw_wr_r),
    .wdata (in_scan_code),
    .raddr (raw_rd_r),
    .rdata (raw_rdata)
  );

  // A character entry never written since reset reads as zero.
  always_comb begin
    out_read_value = 8'h00;
    if (cmd.strobe) begin
      case (src_r)
        sc2a_pkg::SRC_CHAR: out_read_value = chr_rvld_r ? chr_rdata : 8'h00;
        sc2a_pkg::SRC_RAW:  out_read_value = raw_rdata;
        default:            out_read_value = 8'h00;
      endcase
    end
  end

  assign out_value_valid = cmd.strobe & hit_r;
  assign out_alt_seen    = cmd.strobe & alt_r;
  assign out_ctrl_held   = cmd.strobe & ctrl_r;

endmodule

// ===== hdl/scancode_to_ascii_fifo.sv =====
// Top level of the set 1 scan code translator with character and raw code rings.
//
// A word is taken at a rising edge with start high and busy low; busy then
// stays high for one cycle, during which out_strobe is high and the result
// of that word sits on the out_ ports. The receiver cannot hold a result off,
// so it must capture the word in the strobe cycle. The result appears in the
// cycle straight after the accepting edge, so each word occupies the cycle
// in which it is accepted and the strobe cycle. A new word may be offered in
// the cycle after the strobe, so no word is taken while the last is in hand;
// this is set by the registered read port of the ring memories. A push
// word updates the shift, caps lock, control and alt flags, stores the raw
// code and, for printable codes, the translated character. Reads return zero
// with out_value_valid low when their ring is empty; the last-character read
// is always valid, with never-written character entries reading as zero after
// reset. Both rings overwrite their oldest entries when full, and a flush
// empties both without touching the stored data or the key flags.
module scancode_to_ascii_fifo #(
  parameter int RING_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_scan_code,
  output logic       out_strobe,
  output logic [7:0] out_read_value,
  output logic       out_value_valid,
  output logic       out_alt_seen,
  output logic       out_ctrl_held
);

  sc2a_pkg::cmd_t cmd;

  // The controller sequences acceptance and the result cycle.
  sc2a_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the flags, the pointers and both ring memories.
  sc2a_dpath #(.RING_DEPTH(RING_DEPTH)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_scan_code    (in_scan_code),
    .out_read_value  (out_read_value),
    .out_value_valid (out_value_valid),
    .out_alt_seen    (out_alt_seen),
    .out_ctrl_held   (out_ctrl_held)
  );

  assign out_strobe = cmd.strobe;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the set 1 scan code translator with its two rings.
`timescale 1ns / 100ps

module tb_top;

  localparam int RING_DEPTH = 16;

  // Operation codes 5 to 7 are unassigned and must leave the block untouched.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // Highest code with a character in either table; every code above it, up to and
  // past the print limit, translates to nothing.
  localparam logic [7:0] TAB_LAST  = 8'h39;
  localparam logic [7:0] BREAK_BIT = 8'h80;
  localparam logic [7:0] CODE_MAX  = 8'hFF;

  localparam int MAX_REPORTS = 10;

  // One result word as the block should present it.
  typedef struct {
    logic [7:0] value;
    logic       valid;
    logic       alt;
    logic       ctrl;
  } reply_t;

  // The scoreboard keeps its own copy of the key flags and both rings, works out
  // the reply to each accepted word and compares the replies in order of arrival.
  class translator_scoreboard;
    logic [7:0] plain_tab [58];
    logic [7:0] upper_tab [58];
    logic       shift_down, caps_lock, ctrl_down, alt_latched;
    logic [7:0] raw_ring [RING_DEPTH];
    logic [7:0] char_ring [RING_DEPTH];
    int         raw_wr, raw_rd, char_wr, char_rd;
    logic       raw_full_or_part, char_full_or_part;
    reply_t     awaited_replies [$];
    int         errors, checked, read_hits, pushes, overwrites;

    function new();
      plain_tab = '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
                    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
                    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
                    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
                    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
                    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
                    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
                    8'h00, 8'h20};
      upper_tab = '{8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
                    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
                    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
                    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
                    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
                    8'h22, 8'h7C, 8'h00, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56,
                    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
                    8'h00, 8'h20};
      shift_down = 1'b0;
      caps_lock = 1'b0;
      ctrl_down = 1'b0;
      alt_latched = 1'b0;
      foreach (raw_ring[i]) raw_ring[i] = 8'h00;
      foreach (char_ring[i]) char_ring[i] = 8'h00;
      raw_wr = 0;
      raw_rd = 0;
      char_wr = 0;
      char_rd = 0;
      raw_full_or_part = 1'b0;
      char_full_or_part = 1'b0;
      errors = 0;
      checked = 0;
      read_hits = 0;
      pushes = 0;
      overwrites = 0;
    endfunction

    function int step_ptr(int p);
      return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
    endfunction

    // Works out the reply to one accepted word and updates the flags and rings.
    function void translate_word(logic [2:0] op, logic [7:0] code);
      reply_t r;
      logic [7:0] ch;
      r.value = 8'h00;
      r.valid = 1'b0;
      case (op)
        sc2a_pkg::OP_PUSH: begin
          pushes++;
          if (code inside {sc2a_pkg::SC_LSHIFT_MAKE, sc2a_pkg::SC_RSHIFT_MAKE})
            shift_down = 1'b1;
          if (code inside {sc2a_pkg::SC_LSHIFT_BREAK, sc2a_pkg::SC_RSHIFT_BREAK})
            shift_down = 1'b0;
          if (code == sc2a_pkg::SC_CAPS_MAKE) caps_lock = ~caps_lock;
          if (code == sc2a_pkg::SC_CTRL_MAKE) ctrl_down = 1'b1;
          if (code == sc2a_pkg::SC_CTRL_BREAK) ctrl_down = 1'b0;
          if (code == sc2a_pkg::SC_ALT_MAKE) alt_latched = 1'b1;
          if (code <= TAB_LAST && plain_tab[code] != 8'h00) begin
            ch = (shift_down || (caps_lock && code >= sc2a_pkg::CAPS_FIRST)) ?
                 upper_tab[code] : plain_tab[code];
            char_ring[char_wr] = ch;
            char_wr = step_ptr(char_wr);
            char_full_or_part = 1'b1;
          end
          if (raw_full_or_part && raw_wr == raw_rd) overwrites++;
          raw_ring[raw_wr] = code;
          raw_wr = step_ptr(raw_wr);
          raw_full_or_part = 1'b1;
        end
        sc2a_pkg::OP_RD_CHAR: begin
          if (char_full_or_part) begin
            r.value = char_ring[char_rd];
            r.valid = 1'b1;
            char_rd = step_ptr(char_rd);
            if (char_rd == char_wr) char_full_or_part = 1'b0;
          end
        end
        sc2a_pkg::OP_RD_RAW: begin
          if (raw_full_or_part) begin
            r.value = raw_ring[raw_rd];
            r.valid = 1'b1;
            raw_rd = step_ptr(raw_rd);
            if (raw_rd == raw_wr) raw_full_or_part = 1'b0;
          end
        end
        sc2a_pkg::OP_LAST: begin
          r.value = char_ring[(char_wr == 0) ? RING_DEPTH - 1 : char_wr - 1];
          r.valid = 1'b1;
        end
        sc2a_pkg::OP_FLUSH: begin
          raw_wr = 0;
          raw_rd = 0;
          char_wr = 0;
          char_rd = 0;
          raw_full_or_part = 1'b0;
          char_full_or_part = 1'b0;
        end
        default: ;
      endcase
      if (r.valid && op != sc2a_pkg::OP_LAST) read_hits++;
      r.alt = alt_latched;
      r.ctrl = ctrl_down;
      awaited_replies.push_back(r);
    endfunction

    // Compares one strobed result with the oldest reply still awaited.
    function void check_result(logic [7:0] value, logic valid, logic alt, logic ctrl);
      reply_t e;
      checked++;
      if (awaited_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Result %0d arrived with nothing awaited: value %h valid %b alt %b ctrl %b",
                   checked, value, valid, alt, ctrl);
        return;
      end
      e = awaited_replies.pop_front();
      if (value !== e.value || valid !== e.valid || alt !== e.alt || ctrl !== e.ctrl) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Result %0d wrong: expected value %h valid %b alt %b ctrl %b, got %h %b %b %b",
                   checked, e.value, e.valid, e.alt, e.ctrl, value, valid, alt, ctrl);
      end
    endfunction

    function void close_out();
      if (awaited_replies.size() != 0) begin
        errors++;
        $display("%0d results never arrived", awaited_replies.size());
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [2:0] in_operation = sc2a_pkg::OP_PUSH;
  logic [7:0] in_scan_code = 8'h00;
  logic       busy;
  logic       out_strobe;
  logic [7:0] out_read_value;
  logic       out_value_valid;
  logic       out_alt_seen;
  logic       out_ctrl_held;

  translator_scoreboard sb = new();

  // Percentage of cycles in which the sender holds back before offering a word.
  int sender_idle_pct = 0;
  int words_sent = 0;

  scancode_to_ascii_fifo #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_scan_code    (in_scan_code),
    .out_strobe      (out_strobe),
    .out_read_value  (out_read_value),
    .out_value_valid (out_value_valid),
    .out_alt_seen    (out_alt_seen),
    .out_ctrl_held   (out_ctrl_held)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver cannot stall the block, so every strobed word is checked in the
  // cycle it appears. Outputs are read at the edge, before any update of that edge.
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result(out_read_value, out_value_valid, out_alt_seen, out_ctrl_held);
  end

  // Offers one word and returns at the edge that accepts it. While the sender idles
  // the operand ports carry junk, which the block must ignore with start low.
  task automatic send_word(input logic [2:0] op, input logic [7:0] code);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      in_operation <= 3'($urandom_range(OP_SPARE_LAST));
      in_scan_code <= 8'($urandom_range(CODE_MAX));
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_scan_code <= code;
    do @(posedge clk); while (busy !== 1'b0);
    sb.translate_word(op, code);
    words_sent++;
  endtask

  // Codes a typist produces: mostly printable keys, a fair share of modifier makes
  // and breaks, break codes of ordinary keys, and now and then any byte at all.
  function automatic logic [7:0] pick_scan_code();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(TAB_LAST, 1));
    if (r < 75) begin
      case ($urandom_range(7))
        0: return sc2a_pkg::SC_LSHIFT_MAKE;
        1: return sc2a_pkg::SC_RSHIFT_MAKE;
        2: return sc2a_pkg::SC_LSHIFT_BREAK;
        3: return sc2a_pkg::SC_RSHIFT_BREAK;
        4: return sc2a_pkg::SC_CAPS_MAKE;
        5: return sc2a_pkg::SC_CTRL_MAKE;
        6: return sc2a_pkg::SC_CTRL_BREAK;
        default: return sc2a_pkg::SC_ALT_MAKE;
      endcase
    end
    if (r < 85) return 8'($urandom_range(TAB_LAST, 1)) | BREAK_BIT;
    return 8'($urandom_range(CODE_MAX));
  endfunction

  function automatic logic [2:0] pick_read_op();
    int r;
    r = $urandom_range(99);
    if (r < 45) return sc2a_pkg::OP_RD_CHAR;
    if (r < 90) return sc2a_pkg::OP_RD_RAW;
    return sc2a_pkg::OP_LAST;
  endfunction

  // A phase is a string of rounds. Most rounds are a burst of typing followed by a
  // burst of reads; bursts of up to 24 words run both rings past full so that the
  // overwrite path is taken. The remaining rounds flush, peek, use the spare codes
  // or throw in completely random words.
  task automatic run_phase(input int idle_pct, input int n_words);
    int stop_at;
    int pick;
    int run_len;
    stop_at = words_sent + n_words;
    sender_idle_pct = idle_pct;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_len = $urandom_range(24, 1);
        repeat (run_len) send_word(sc2a_pkg::OP_PUSH, pick_scan_code());
        run_len = $urandom_range(24);
        repeat (run_len) send_word(pick_read_op(), 8'($urandom_range(CODE_MAX)));
      end else if (pick < 78) begin
        send_word(sc2a_pkg::OP_FLUSH, 8'($urandom_range(CODE_MAX)));
      end else if (pick < 86) begin
        send_word(sc2a_pkg::OP_LAST, 8'($urandom_range(CODE_MAX)));
      end else if (pick < 92) begin
        send_word(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
                  8'($urandom_range(CODE_MAX)));
      end else begin
        run_len = $urandom_range(8, 1);
        repeat (run_len)
          send_word(3'($urandom_range(OP_SPARE_LAST)), 8'($urandom_range(CODE_MAX)));
      end
    end
  endtask

  initial begin
    int guard;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening. Character entries are marked unwritten at reset, so a peek
    // at the last character reads zero and is still valid; both rings start empty.
    send_word(sc2a_pkg::OP_LAST, 8'h00);
    send_word(sc2a_pkg::OP_RD_CHAR, CODE_MAX);
    send_word(sc2a_pkg::OP_RD_RAW, 8'h00);
    // Smallest and largest codes: neither is printable, both land in the raw ring.
    send_word(sc2a_pkg::OP_PUSH, 8'h00);
    send_word(sc2a_pkg::OP_PUSH, CODE_MAX);
    // A digit plain, then with left shift held, then with caps lock on, which
    // only affects codes from the first letter row upwards.
    send_word(sc2a_pkg::OP_PUSH, 8'h02);
    send_word(sc2a_pkg::OP_PUSH, sc2a_pkg::SC_LSHIFT_MAKE);
    send_word(sc2a_pkg::OP_PUSH, 8'h02);
    send_word(sc2a_pkg::OP_PUSH, sc2a_pkg::SC_LSHIFT_BREAK);
    send_word(sc2a_pkg::OP_PUSH, sc2a_pkg::SC_CAPS_MAKE);
    send_word(sc2a_pkg::OP_PUSH, 8'h02);
    send_word(sc2a_pkg::OP_PUSH, sc2a_pkg::CAPS_FIRST);
    // Right shift, and the keypad star key, which is a character and not a shift.
    send_word(sc2a_pkg::OP_PUSH, sc2a_pkg::SC_RSHIFT_MAKE);
    send_word(sc2a_pkg::OP_PUSH, 8'h37);
    send_word(sc2a_pkg::OP_PUSH, sc2a_pkg::SC_RSHIFT_BREAK);
    // Control comes and goes; alt stays set for the rest of the run.
    send_word(sc2a_pkg::OP_PUSH, sc2a_pkg::SC_CTRL_MAKE);
    send_word(sc2a_pkg::OP_PUSH, sc2a_pkg::SC_ALT_MAKE);
    send_word(sc2a_pkg::OP_PUSH, sc2a_pkg::SC_CTRL_BREAK);
    // The code at the print limit and the one above it, then the other operations.
    send_word(sc2a_pkg::OP_PUSH, sc2a_pkg::PRINT_LIMIT);
    send_word(sc2a_pkg::OP_PUSH, sc2a_pkg::PRINT_LIMIT + 8'h01);
    send_word(sc2a_pkg::OP_RD_CHAR, 8'h00);
    send_word(sc2a_pkg::OP_RD_RAW, 8'h00);
    send_word(sc2a_pkg::OP_FLUSH, 8'h00);
    send_word(sc2a_pkg::OP_LAST, 8'h00);
    send_word(OP_SPARE_LAST, CODE_MAX);

    // Random part: the sender idles often, then more often, then never.
    run_phase(32, 500);
    run_phase(45, 500);
    run_phase(0, 500);

    // Drain: wait for every awaited result, then idle on in case a stray strobe
    // follows.
    start <= 1'b0;
    guard = 0;
    while (sb.awaited_replies.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    sb.close_out();

    $display("Run covered %0d words: %0d scan code pushes, %0d ring reads that returned data,",
             words_sent, sb.pushes, sb.read_hits);
    $display("%0d raw ring overwrites when full, %0d results checked, %0d failures",
             sb.overwrites, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: stops the run with errors if it hangs.
  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sc2a_pkg.sv
hdl/sc2a_ram.sv
hdl/sc2a_ctrl.sv
hdl/sc2a_dpath.sv
hdl/scancode_to_ascii_fifo.sv
dv/tb_top.sv
